[sv/spt_pkg.sv]
// Package: shared types, codes and the descriptor builder for the section table engine.
`default_nettype none
package spt_pkg;

  typedef enum logic [2:0] {
    K_MAP_AT   = 3'd0,
    K_MAP_FREE = 3'd1,
    K_UNMAP    = 3'd2,
    K_CLEAR    = 3'd3,
    K_LOOKUP   = 3'd4
  } spt_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_OVERFLOW  = 2'd2
  } spt_status_t;

  typedef enum logic [1:0] {
    CM_WRITE_BACK    = 2'd0,
    CM_WRITE_THROUGH = 2'd1,
    CM_DEVICE        = 2'd2,
    CM_INHIBIT       = 2'd3
  } spt_cache_mode_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MAP,
    S_SEARCH,
    S_UNMAP,
    S_CLEAR,
    S_LOOKUP,
    S_DONE
  } spt_state_t;

  localparam logic [1:0] SECTION_TYPE = 2'b10;
  localparam logic [2:0] TEX_WB       = 3'h5;
  localparam logic [2:0] TEX_WT       = 3'h6;
  localparam logic [1:0] AP_PRIV      = 2'h1;
  localparam logic [1:0] AP_RO        = 2'h2;
  localparam logic [1:0] AP_RW        = 2'h3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  space;
    logic [11:0] virt_section;
    logic [11:0] phys_section;
    logic [12:0] section_count;
    logic [2:0]  access_rights;
    logic [1:0]  cache_mode;
    logic        non_global;
  } spt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] found_section;
    logic [31:0] descriptor;
  } spt_result_t;

  // Low 20 bits of a section descriptor; the physical section fills bits 31:20.
  function automatic logic [19:0] build_desc_lo(input logic [2:0] rights,
                                                input logic [1:0] mode,
                                                input logic       ng,
                                                input logic       dce);
    logic [1:0] m;
    logic [1:0] ap;
    logic [2:0] tex;
    logic       c;
    logic       b;
    m   = dce ? mode : CM_INHIBIT;
    tex = 3'd0;
    c   = 1'b0;
    b   = 1'b0;
    if (!ng) begin
      ap = AP_PRIV;
    end else if (rights[0] && rights[1]) begin
      ap = AP_RW;
    end else if (rights[0]) begin
      ap = AP_RO;
    end else begin
      ap = AP_PRIV;
    end
    unique case (spt_cache_mode_t'(m))
      CM_WRITE_BACK: begin
        tex = TEX_WB;
        b   = 1'b1;
      end
      CM_WRITE_THROUGH: begin
        tex = TEX_WT;
        c   = 1'b1;
      end
      CM_DEVICE: begin
        b = 1'b1;
      end
      default: begin
        if (ng) begin
          tex = TEX_WT;
          c   = 1'b1;
        end
      end
    endcase
    return {2'b00, ng, 2'b00, tex, ap, 5'b00000, ~rights[2], c, b, SECTION_TYPE};
  endfunction

endpackage
`default_nettype wire

[sv/spt_if.sv]
// Interfaces: request and response channels of the section table engine.
`default_nettype none
interface spt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  space;
  logic [11:0] virt_section;
  logic [11:0] phys_section;
  logic [12:0] section_count;
  logic [2:0]  access_rights;
  logic [1:0]  cache_mode;
  logic        non_global;

  modport source(output valid, kind, space, virt_section, phys_section, section_count,
                 access_rights, cache_mode, non_global, input ready);
  modport sink(input valid, kind, space, virt_section, phys_section, section_count,
               access_rights, cache_mode, non_global, output ready);
endinterface

interface spt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] found_section;
  logic [31:0] descriptor;

  modport source(output valid, status, found_section, descriptor, input ready);
  modport sink(input valid, status, found_section, descriptor, output ready);
endinterface
`default_nettype wire

[sv/spt_table_ram.sv]
// Single-port table RAM with registered read data.
`default_nettype none
module spt_table_ram #(
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [31:0]              wdata,
  output      logic [31:0]              rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[sv/spt_ctrl.sv]
// Sequencer: walks the table for maps, searches, clears and lookups.
`default_nettype none
module spt_ctrl import spt_pkg::*; #(
  parameter int ENTRIES    = 4096,
  parameter int NUM_SPACES = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  data_cache_enabled,
  input  wire logic                                  req_valid,
  output      logic                                  req_ready,
  input  wire spt_req_t                              req,
  output      logic                                  res_valid,
  input  wire logic                                  res_take,
  output      spt_result_t                           res,
  output      logic                                  mem_we,
  output      logic                                  mem_re,
  output      logic [$clog2(NUM_SPACES*ENTRIES)-1:0] mem_addr,
  output      logic [31:0]                           mem_wdata,
  input  wire logic [31:0]                           mem_rdata
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = IW + 1;
  localparam int AW  = $clog2(NUM_SPACES*ENTRIES);
  localparam int SPW = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
  localparam logic [CW-1:0]  IDX_END  = CW'(ENTRIES);
  localparam logic [CW-1:0]  IDX_LAST = CW'(ENTRIES - 1);
  localparam logic [IW-1:0]  CHK_LAST = IW'(ENTRIES - 1);
  localparam logic [SPW-1:0] SP_LAST  = SPW'(NUM_SPACES - 1);
  localparam logic [AW-1:0]  ENT_A    = AW'(ENTRIES);

  spt_state_t  state, state_next;
  logic [CW-1:0]  idx, idx_next;
  logic [SPW-1:0] sp, sp_next;
  logic           rvalid;
  logic [IW-1:0]  chk_idx;
  logic [12:0]    cnt, cnt_next;
  logic [12:0]    i, i_next;
  logic [12:0]    run, run_next;
  logic [IW-1:0]  start, start_next;
  logic [11:0]    phys, phys_next;
  logic [19:0]    desc_lo, desc_lo_next;
  spt_result_t    res_next;

  logic [19:0]    lo_in;
  logic           virt_ok;
  logic           space_ok;
  logic [12:0]    run1;
  logic [IW-1:0]  start_c;

  assign lo_in    = build_desc_lo(req.access_rights, req.cache_mode, req.non_global,
                                  data_cache_enabled);
  assign virt_ok  = {1'b0, req.virt_section} < 13'(ENTRIES);
  assign space_ok = 9'(req.space) < 9'(NUM_SPACES);
  assign run1     = run + 13'd1;
  assign start_c  = (run == 13'd0) ? chk_idx : start;
  assign mem_addr = AW'(sp) * ENT_A + AW'(idx[IW-1:0]);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    sp_next      = sp;
    cnt_next     = cnt;
    i_next       = i;
    run_next     = run;
    start_next   = start;
    phys_next    = phys;
    desc_lo_next = desc_lo;
    res_next     = res;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wdata    = '0;
    req_ready    = (state == S_IDLE);
    res_valid    = (state == S_DONE);
    unique case (state)
      S_INIT: begin
        mem_we = 1'b1;
        if (idx == IDX_LAST) begin
          idx_next = '0;
          if (sp == SP_LAST) begin
            state_next = S_IDLE;
          end else begin
            sp_next = sp + SPW'(1);
          end
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cnt_next     = (req.section_count == 13'd0) ? 13'd1 : req.section_count;
          desc_lo_next = lo_in;
          phys_next    = req.phys_section;
          i_next       = '0;
          run_next     = '0;
          start_next   = '0;
          res_next     = '0;
          sp_next      = SPW'(req.space);
          idx_next     = '0;
          state_next   = S_DONE;
          if (req.kind <= K_LOOKUP) begin
            if (!space_ok) begin
              res_next.status = ST_NOT_FOUND;
            end else begin
              unique case (spt_kind_t'(req.kind))
                K_MAP_AT: begin
                  if (virt_ok) begin
                    idx_next            = CW'(req.virt_section);
                    res_next.descriptor = {req.phys_section, lo_in};
                    state_next          = S_MAP;
                  end else begin
                    res_next.status = ST_OVERFLOW;
                  end
                end
                K_MAP_FREE: state_next = S_SEARCH;
                K_UNMAP: begin
                  if (virt_ok) begin
                    idx_next   = CW'(req.virt_section);
                    state_next = S_UNMAP;
                  end
                end
                K_CLEAR:  state_next = S_CLEAR;
                K_LOOKUP: state_next = S_LOOKUP;
                default:  state_next = S_DONE;
              endcase
            end
          end
        end
      end
      S_MAP: begin
        if (idx == IDX_END) begin
          res_next.status = ST_OVERFLOW;
          state_next      = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {phys, desc_lo};
          phys_next = phys + 12'd1;
          idx_next  = idx + CW'(1);
          i_next    = i + 13'd1;
          if (i + 13'd1 == cnt) begin
            state_next = S_DONE;
          end
        end
      end
      S_UNMAP: begin
        mem_we     = 1'b1;
        state_next = S_DONE;
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        if (idx == IDX_LAST) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_SEARCH: begin
        mem_re = (idx != IDX_END);
        if (mem_re) begin
          idx_next = idx + CW'(1);
        end
        if (rvalid) begin
          if (mem_rdata == 32'd0 && run1 >= cnt) begin
            res_next.found_section = 12'(start_c);
            res_next.descriptor    = {phys, desc_lo};
            idx_next               = CW'(start_c);
            i_next                 = '0;
            state_next             = S_MAP;
          end else begin
            if (mem_rdata == 32'd0) begin
              run_next   = run1;
              start_next = start_c;
            end else begin
              run_next = '0;
            end
            if (chk_idx == CHK_LAST) begin
              res_next.status = ST_NOT_FOUND;
              state_next      = S_DONE;
            end
          end
        end
      end
      S_LOOKUP: begin
        mem_re = (idx != IDX_END);
        if (mem_re) begin
          idx_next = idx + CW'(1);
        end
        if (rvalid) begin
          if (mem_rdata != 32'd0 && mem_rdata[31:20] == phys) begin
            res_next.found_section = 12'(chk_idx);
            state_next             = S_DONE;
          end else if (chk_idx == CHK_LAST) begin
            res_next.status = ST_NOT_FOUND;
            state_next      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      idx    <= '0;
      sp     <= '0;
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      sp     <= sp_next;
      rvalid <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx[IW-1:0];
    cnt     <= cnt_next;
    i       <= i_next;
    run     <= run_next;
    start   <= start_next;
    phys    <= phys_next;
    desc_lo <= desc_lo_next;
    res     <= res_next;
  end

endmodule
`default_nettype wire

[sv/section_page_table_engine.sv]
// Top level: section page table engine with config register and output register.
//
//   channel | dir | payload                                          | accepted when
//   req     | in  | kind space virt/phys_section count rights mode ng | req.valid & req.ready
//   rsp     | out | status found_section descriptor                  | rsp.valid & rsp.ready
//   cfg     | in  | data_cache_enabled (cfg_write_data)              | cfg_write_en
//
// One item at a time. Bad space, unknown kind or unmap past the table go straight to the
// result; unmap writes one entry, map at writes count entries from the index (overflow at
// the table end), clear zeroes the space; free search and lookup read the space in order,
// and a found free run is then mapped. The table RAM is touched at most once a cycle.
// After reset the RAM is cleared with req.ready low.
// A held result in the output register stalls the next result, and acceptance after that one.
`default_nettype none
module section_page_table_engine import spt_pkg::*; #(
  parameter int ENTRIES    = 4096,
  parameter int NUM_SPACES = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write_en,
  input  wire logic  cfg_write_data,
  spt_req_if.sink    req,
  spt_rsp_if.source  rsp
);

  localparam int AW = $clog2(NUM_SPACES*ENTRIES);

  logic          data_cache_enabled;
  spt_req_t      req_item;
  spt_result_t   res;
  logic          res_valid;
  logic          res_take;
  logic          out_valid;
  spt_result_t   out_item;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  assign req_item = '{kind: req.kind, space: req.space, virt_section: req.virt_section,
                      phys_section: req.phys_section, section_count: req.section_count,
                      access_rights: req.access_rights, cache_mode: req.cache_mode,
                      non_global: req.non_global};

  assign res_take          = !out_valid || rsp.ready;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_item.status;
  assign rsp.found_section = out_item.found_section;
  assign rsp.descriptor    = out_item.descriptor;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_cache_enabled <= 1'b1;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        data_cache_enabled <= cfg_write_data;
      end
      if (res_take) begin
        out_valid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_item <= res;
    end
  end

  spt_ctrl #(
    .ENTRIES    (ENTRIES),
    .NUM_SPACES (NUM_SPACES)
  ) u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .data_cache_enabled (data_cache_enabled),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req                (req_item),
    .res_valid          (res_valid),
    .res_take           (res_take),
    .res                (res),
    .mem_we             (mem_we),
    .mem_re             (mem_re),
    .mem_addr           (mem_addr),
    .mem_wdata          (mem_wdata),
    .mem_rdata          (mem_rdata)
  );

  spt_table_ram #(
    .DEPTH (NUM_SPACES*ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

[sv/spt_checker.sv]
// Checker: port-level assertions for the section page table engine, with its bind.
`default_nettype none
module spt_checker import spt_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic [11:0] rsp_found_section,
  input wire logic [31:0] rsp_descriptor
);

  // one item in flight: acceptance drops ready
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high after an item was accepted");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
    $stable(rsp_found_section) && $stable(rsp_descriptor))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_NOT_FOUND ||
    rsp_status == ST_OVERFLOW)
    else $error("undefined status code");

  a_not_found_no_desc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_NOT_FOUND |-> rsp_descriptor == 32'd0)
    else $error("descriptor given with not-found status");

  a_desc_is_section: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_descriptor != 32'd0 |-> rsp_descriptor[1:0] == SECTION_TYPE)
    else $error("descriptor is not a section entry");

endmodule

bind section_page_table_engine spt_checker u_spt_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_found_section (rsp.found_section),
  .rsp_descriptor    (rsp.descriptor)
);
`default_nettype wire

[bench/tb_top.sv]
// Testbench: directed and random requests; results checked against given or predicted values.
`timescale 1ns / 1ps
module tb_top;
  import spt_pkg::*;

  localparam int ENTRIES        = 4096;
  localparam int NUM_SPACES     = 4;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_CYCLES    = 20000;
  localparam int PRINT_CAP      = 50;

  // reserved request kinds, answered with an all-zero result
  localparam logic [2:0] KIND_RSVD_A = 3'd5;
  localparam logic [2:0] KIND_RSVD_B = 3'd6;
  localparam logic [2:0] KIND_RSVD_C = 3'd7;

  typedef struct {
    spt_req_t    req;
    bit          typed;
    spt_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;

  spt_req_if req_ch();
  spt_rsp_if rsp_ch();

  section_page_table_engine #(
    .ENTRIES(ENTRIES),
    .NUM_SPACES(NUM_SPACES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  logic [31:0] section_table [NUM_SPACES][ENTRIES];
  logic        dcache_on;
  spt_result_t results_due[$];
  spt_result_t head_result;
  dir_row_t    dir_rows[$];
  int          mismatch_count;
  int          results_checked;
  int          kind_count [8];
  int          quiet_cycles;
  bit          steady_run;
  bit          long_hold;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] make_descriptor(logic [11:0] phys, logic [2:0] rights,
                                                  logic [1:0] mode, logic ng);
    logic [1:0] m;
    logic [1:0] ap;
    logic [2:0] tex;
    logic       c;
    logic       b;
    m  = dcache_on ? mode : CM_INHIBIT;
    ap = !ng ? AP_PRIV : (rights[0] && rights[1]) ? AP_RW : rights[0] ? AP_RO : AP_PRIV;
    case (m)
      CM_WRITE_BACK:    {tex, c, b} = {TEX_WB, 1'b0, 1'b1};
      CM_WRITE_THROUGH: {tex, c, b} = {TEX_WT, 1'b1, 1'b0};
      CM_DEVICE:        {tex, c, b} = {3'd0, 1'b0, 1'b1};
      default:          {tex, c, b} = ng ? {TEX_WT, 1'b1, 1'b0} : 5'd0;
    endcase
    return {phys, 2'b00, ng, 2'b00, tex, ap, 1'b0, 4'b0000, ~rights[2], c, b, SECTION_TYPE};
  endfunction

  function automatic logic [1:0] write_run(int sp, int start, spt_req_t r, int n,
                                           output logic [31:0] first);
    logic [11:0] p;
    first = '0;
    for (int i = 0; i < n; i++) begin
      if (start + i >= ENTRIES) return ST_OVERFLOW;
      p = r.phys_section + 12'(i);
      section_table[sp][start + i] = make_descriptor(p, r.access_rights, r.cache_mode,
                                                     r.non_global);
      if (i == 0) first = section_table[sp][start];
    end
    return ST_OK;
  endfunction

  function automatic spt_result_t predict_item(spt_req_t r);
    spt_result_t res;
    logic [31:0] first;
    int          n;
    int          sp;
    int          run;
    int          start;
    bit          hit;
    res   = '0;
    first = '0;
    n     = (r.section_count == 0) ? 1 : int'(r.section_count);
    sp    = int'(r.space);
    run   = 0;
    start = 0;
    hit   = 1'b0;
    case (r.kind)
      K_MAP_AT: begin
        res.status     = write_run(sp, int'(r.virt_section), r, n, first);
        res.descriptor = first;
      end
      K_MAP_FREE: begin
        for (int t = 0; t < ENTRIES && !hit; t++) begin
          if (section_table[sp][t] != 0) begin
            run = 0;
          end else begin
            if (run == 0) start = t;
            run++;
            if (run >= n) hit = 1'b1;
          end
        end
        if (hit) begin
          res.found_section = 12'(start);
          res.status        = write_run(sp, start, r, n, first);
          res.descriptor    = first;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      K_UNMAP: section_table[sp][r.virt_section] = '0;
      K_CLEAR: begin
        for (int t = 0; t < ENTRIES; t++) section_table[sp][t] = '0;
      end
      K_LOOKUP: begin
        res.status = ST_NOT_FOUND;
        for (int t = 0; t < ENTRIES && !hit; t++) begin
          if (section_table[sp][t] != 0 && section_table[sp][t][31:20] == r.phys_section) begin
            hit               = 1'b1;
            res.status        = ST_OK;
            res.found_section = 12'(t);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic spt_req_t mk_req(int kind, int space, int virt, int phys, int count,
                                      int rights, int mode, int ng);
    spt_req_t r;
    r.kind          = 3'(kind);
    r.space         = 2'(space);
    r.virt_section  = 12'(virt);
    r.phys_section  = 12'(phys);
    r.section_count = 13'(count);
    r.access_rights = 3'(rights);
    r.cache_mode    = 2'(mode);
    r.non_global    = 1'(ng);
    return r;
  endfunction

  // Maps cluster in the low 256 sections so unmaps and lookups land on live entries.
  function automatic spt_req_t random_request();
    spt_req_t r;
    int       pick;
    int       size_pick;
    pick      = $urandom_range(0, 99);
    size_pick = $urandom_range(0, 99);
    r.space         = 2'($urandom_range(0, NUM_SPACES - 1));
    r.virt_section  = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 255)) : 12'($urandom);
    r.phys_section  = 12'($urandom);
    r.access_rights = 3'($urandom);
    r.cache_mode    = 2'($urandom);
    r.non_global    = 1'($urandom);
    r.section_count = (size_pick < 80) ? 13'($urandom_range(0, 8)) :
                      (size_pick < 96) ? 13'($urandom_range(9, 300)) :
                                         13'($urandom_range(4000, 8191));
    if (pick < 30) begin
      r.kind = K_MAP_AT;
    end else if (pick < 50) begin
      r.kind = K_MAP_FREE;
    end else if (pick < 65) begin
      r.kind = K_UNMAP;
    end else if (pick < 88) begin
      r.kind = K_LOOKUP;
      if ($urandom_range(0, 9) < 7)
        r.phys_section = section_table[r.space][$urandom_range(0, 255)][31:20];
    end else if (pick < 93) begin
      r.kind = K_CLEAR;
    end else begin
      r.kind = 3'($urandom_range(KIND_RSVD_A, KIND_RSVD_C));
    end
    return r;
  endfunction

  task automatic add_row(input spt_req_t r, input bit typed, input int st, input int fs,
                         input logic [31:0] desc);
    dir_row_t row;
    row.req                = r;
    row.typed              = typed;
    row.res.status         = 2'(st);
    row.res.found_section  = 12'(fs);
    row.res.descriptor     = desc;
    dir_rows.push_back(row);
  endtask

  task automatic send_request(input spt_req_t r, input bit typed, input spt_result_t want);
    spt_result_t pred;
    if (!steady_run && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= r.kind;
    req_ch.space         <= r.space;
    req_ch.virt_section  <= r.virt_section;
    req_ch.phys_section  <= r.phys_section;
    req_ch.section_count <= r.section_count;
    req_ch.access_rights <= r.access_rights;
    req_ch.cache_mode    <= r.cache_mode;
    req_ch.non_global    <= r.non_global;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    pred = predict_item(r);
    results_due.push_back(typed ? want : pred);
    kind_count[r.kind]++;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_request(random_request(), 1'b0, '0);
  endtask

  task automatic write_cache_cfg(input logic value);
    req_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    dcache_on = value;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (results_due.size() == 0) begin
        flag_mismatch("unexpected result", 32'(rsp_ch.status), '0);
      end else begin
        head_result = results_due.pop_front();
        if (rsp_ch.status !== head_result.status)
          flag_mismatch("status", 32'(rsp_ch.status), 32'(head_result.status));
        if (rsp_ch.found_section !== head_result.found_section)
          flag_mismatch("found_section", 32'(rsp_ch.found_section),
                        32'(head_result.found_section));
        if (rsp_ch.descriptor !== head_result.descriptor)
          flag_mismatch("descriptor", rsp_ch.descriptor, head_result.descriptor);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!steady_run && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    cfg_write_en         = 1'b0;
    cfg_write_data       = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.kind          = '0;
    req_ch.space         = '0;
    req_ch.virt_section  = '0;
    req_ch.phys_section  = '0;
    req_ch.section_count = '0;
    req_ch.access_rights = '0;
    req_ch.cache_mode    = '0;
    req_ch.non_global    = 1'b0;
    quiet_cycles         = 0;
    mismatch_count       = 0;
    results_checked      = 0;
    steady_run           = 1'b0;
    long_hold            = 1'b0;
    dcache_on            = 1'b1;
    foreach (kind_count[k]) kind_count[k] = 0;
    foreach (section_table[s, e]) section_table[s][e] = '0;

    // empty tables, cache on
    add_row(mk_req(K_LOOKUP, 0, 0, 0, 1, 0, CM_WRITE_BACK, 0), 1, ST_NOT_FOUND, 0, 32'h0);
    add_row(mk_req(K_MAP_AT, 0, 0, 0, 0, 7, CM_WRITE_BACK, 1), 1, ST_OK, 0, 32'h0002_5C06);
    add_row(mk_req(K_LOOKUP, 0, 0, 0, 1, 0, CM_WRITE_BACK, 0), 1, ST_OK, 0, 32'h0);
    add_row(mk_req(K_MAP_AT, 1, 4095, 4095, 2, 0, CM_WRITE_THROUGH, 0),
            1, ST_OVERFLOW, 0, 32'hFFF0_641A);
    add_row(mk_req(K_MAP_AT, 2, 4000, 4090, 8191, 1, CM_DEVICE, 1), 0, 0, 0, 0);
    add_row(mk_req(K_MAP_FREE, 1, 0, 7, 1, 3, CM_INHIBIT, 1), 0, 0, 0, 0);
    add_row(mk_req(K_MAP_FREE, 1, 0, 7, 4096, 3, CM_INHIBIT, 1), 1, ST_NOT_FOUND, 0, 32'h0);
    add_row(mk_req(K_MAP_FREE, 3, 0, 7, 8191, 3, CM_INHIBIT, 1), 1, ST_NOT_FOUND, 0, 32'h0);
    add_row(mk_req(K_MAP_FREE, 3, 0, 12'h800, 4096, 4, CM_INHIBIT, 0), 0, 0, 0, 0);
    add_row(mk_req(K_LOOKUP, 3, 0, 12'h900, 1, 0, CM_WRITE_BACK, 0), 0, 0, 0, 0);
    add_row(mk_req(K_CLEAR, 3, 0, 0, 1, 0, CM_WRITE_BACK, 0), 1, ST_OK, 0, 32'h0);
    add_row(mk_req(K_LOOKUP, 3, 0, 12'h900, 1, 0, CM_WRITE_BACK, 0), 1, ST_NOT_FOUND, 0, 32'h0);
    add_row(mk_req(K_UNMAP, 0, 0, 0, 1, 0, CM_WRITE_BACK, 0), 1, ST_OK, 0, 32'h0);
    add_row(mk_req(K_LOOKUP, 0, 0, 0, 1, 0, CM_WRITE_BACK, 0), 1, ST_NOT_FOUND, 0, 32'h0);
    add_row(mk_req(K_MAP_AT, 0, 12'hAAA, 12'h555, 3, 2, CM_WRITE_BACK, 1), 0, 0, 0, 0);
    add_row(mk_req(K_MAP_AT, 0, 12'h555, 12'hAAA, 1, 5, CM_INHIBIT, 1), 0, 0, 0, 0);
    add_row(mk_req(K_MAP_AT, 2, 0, 0, 4096, 7, CM_DEVICE, 0), 0, 0, 0, 0);
    add_row(mk_req(K_MAP_FREE, 2, 0, 1, 1, 7, CM_DEVICE, 0), 1, ST_NOT_FOUND, 0, 32'h0);
    add_row(mk_req(K_LOOKUP, 2, 0, 12'hFFF, 1, 0, CM_WRITE_BACK, 0), 0, 0, 0, 0);
    add_row(mk_req(K_UNMAP, 1, 4095, 0, 1, 0, CM_WRITE_BACK, 0), 1, ST_OK, 0, 32'h0);
    add_row(mk_req(KIND_RSVD_A, 3, 4095, 4095, 8191, 7, CM_INHIBIT, 1), 1, ST_OK, 0, 32'h0);
    add_row(mk_req(KIND_RSVD_B, 3, 4095, 4095, 8191, 7, CM_INHIBIT, 1), 1, ST_OK, 0, 32'h0);
    add_row(mk_req(KIND_RSVD_C, 3, 4095, 4095, 8191, 7, CM_INHIBIT, 1), 1, ST_OK, 0, 32'h0);
    add_row(mk_req(K_CLEAR, 2, 0, 0, 1, 0, CM_WRITE_BACK, 0), 1, ST_OK, 0, 32'h0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_cache_cfg(1'b1);
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    write_cache_cfg(1'b0);
    long_hold = 1'b1;
    run_random(45);

    write_cache_cfg(1'b1);
    run_random(45);

    write_cache_cfg(1'b0);
    steady_run = 1'b1;
    run_random(30);

    req_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d map-at, %0d map-free, %0d unmap, %0d clear, %0d lookup, %0d reserved",
             kind_count[K_MAP_AT], kind_count[K_MAP_FREE], kind_count[K_UNMAP],
             kind_count[K_CLEAR], kind_count[K_LOOKUP],
             kind_count[KIND_RSVD_A] + kind_count[KIND_RSVD_B] + kind_count[KIND_RSVD_C]);
    $display("requests with data cache on and off; %0d results checked, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[section_page_table_engine.f]
sv/spt_pkg.sv
sv/spt_if.sv
sv/spt_table_ram.sv
sv/spt_ctrl.sv
sv/section_page_table_engine.sv
sv/spt_checker.sv
bench/tb_top.sv
